FILE: rtl/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, codes and alphabet functions of the streaming base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam logic       MODE_ENCODE = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR   = 2'd1;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'd61;

  // Depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // One finished group, ready to be expanded into result items
  typedef struct packed {
    logic [23:0] acc;     // group bits, first item in the top bits
    logic        is_dec;  // 1 decode job, 0 encode job
    logic [2:0]  cnt;     // number of result items, 1..4
    logic [1:0]  npad;    // trailing '=' characters of an encode job
    logic        last;    // group closes the buffer
    logic [1:0]  err;     // error code carried by every item
  } job_t;

  // Map a sextet to its alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'd65 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'd71 + {2'b00, s};
    end else if (s < 6'd62) begin
      c = {2'b00, s} - 8'd4;
    end else if (s == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

  // Map a character to {invalid, sextet}; invalid characters give zero
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = {1'b0, 6'(c - 8'd65)};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = {1'b0, 6'(c - 8'd71)};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b0, 6'(c + 8'd4)};
    end else if (c == 8'd43) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'd47) begin
      r = {1'b0, 6'd63};
    end else begin
      r = {1'b1, 6'd0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/b64c_front.sv
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input items, gathers groups and classifies pads and errors; each
// closed group leaves as one job toward the queue.
// ----------------------------------------------------------------------------
module b64c_front import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       acc_en,     // an item is accepted this cycle
  input  logic [7:0] data,
  input  logic       last,
  output logic       push,
  output job_t       job
);

  logic        mode_r;
  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        bad_r, bad_nxt;
  logic [1:0]  padm_r, padm_nxt;

  logic [6:0]  sx;
  logic [5:0]  v;
  logic        bad_t;
  logic [1:0]  padm_t;
  logic [1:0]  drop;

  // Work out the group update and the job for the accepted item
  always_comb begin
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    bad_nxt  = bad_r;
    padm_nxt = padm_r;
    push     = 1'b0;
    job      = '0;
    sx       = dec_sextet(data);
    v        = sx[5:0];
    bad_t    = bad_r;
    padm_t   = padm_r;
    drop     = 2'd0;
    if (mode_r == MODE_ENCODE) begin
      case (pos_r)
        2'd0:    acc_nxt = {data, acc_r[15:0]};
        2'd1:    acc_nxt = {acc_r[23:16], data, acc_r[7:0]};
        default: acc_nxt = {acc_r[23:8], data};
      endcase
      job.acc    = acc_nxt;
      job.is_dec = 1'b0;
      job.cnt    = 3'd4;
      job.err    = ERR_NONE;
      if (pos_r == 2'd2) begin
        push      = 1'b1;
        job.npad  = 2'd0;
        job.last  = last;
      end else if (last) begin
        push      = 1'b1;
        job.npad  = (pos_r == 2'd1) ? 2'd1 : 2'd2;
        job.last  = 1'b1;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end else begin
      // classify the character
      if (data == PAD_CHAR) begin
        v = 6'd0;
        if (pos_r < 2'd2) bad_t = 1'b1;
        else padm_t = padm_r + 2'd1;
      end else begin
        if (sx[6]) bad_t = 1'b1;
        if (padm_r != 2'd0) bad_t = 1'b1;
      end
      acc_nxt    = {acc_r[17:0], v};
      bad_nxt    = bad_t;
      padm_nxt   = padm_t;
      job.is_dec = 1'b1;
      job.npad   = 2'd0;
      if (pos_r < 2'd3) begin
        if (last) begin
          push     = 1'b1;
          job.acc  = 24'd0;
          job.cnt  = 3'd1;
          job.last = 1'b1;
          job.err  = ERR_INCOMPLETE;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end else begin
        if (padm_t != 2'd0) begin
          if (last && !bad_t) drop = padm_t;
          else bad_t = 1'b1;
        end
        push     = 1'b1;
        job.acc  = acc_nxt;
        job.cnt  = 3'd3 - {1'b0, drop};
        job.last = last;
        job.err  = bad_t ? ERR_BAD_CHAR : ERR_NONE;
      end
    end
    // a closed group starts fresh
    if (push) begin
      acc_nxt  = 24'd0;
      pos_nxt  = 2'd0;
      bad_nxt  = 1'b0;
      padm_nxt = 2'd0;
    end
  end

  // Hold mode and group state; a mode write drops the partial group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      acc_r  <= 24'd0;
      pos_r  <= 2'd0;
      bad_r  <= 1'b0;
      padm_r <= 2'd0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      acc_r  <= 24'd0;
      pos_r  <= 2'd0;
      bad_r  <= 1'b0;
      padm_r <= 2'd0;
    end else if (acc_en) begin
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
      bad_r  <= bad_nxt;
      padm_r <= padm_nxt;
    end
  end

endmodule

FILE: rtl/b64c_queue.sv
// ----------------------------------------------------------------------------
// b64c_queue
// Short job queue between front and back, with push and pop in one cycle.
// ----------------------------------------------------------------------------
module b64c_queue import b64c_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_MAX) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PTR_MAX) ? '0 : rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

FILE: rtl/b64c_back.sv
// ----------------------------------------------------------------------------
// b64c_back
// Expands the head job into result items, one per cycle while not stalled,
// into an output register that the result channel drains.
// ----------------------------------------------------------------------------
module b64c_back import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data,
  output logic       out_last,
  output logic [1:0] out_err
);

  logic [1:0] idx_r, idx_nxt;
  logic       ov_r;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic [1:0] err_r;
  logic       load, end_idx;
  logic [5:0] sx;

  assign load    = head_valid && (!ov_r || !out_stall);
  assign end_idx = ({1'b0, idx_r} == head_job.cnt - 3'd1);
  assign pop     = load && end_idx;
  assign idx_nxt = pop ? 2'd0 : idx_r + 2'd1;

  // Select the item at the current index
  always_comb begin
    case (idx_r)
      2'd0:    sx = head_job.acc[23:18];
      2'd1:    sx = head_job.acc[17:12];
      2'd2:    sx = head_job.acc[11:6];
      default: sx = head_job.acc[5:0];
    endcase
    if (head_job.is_dec) begin
      case (idx_r)
        2'd0:    data_nxt = head_job.acc[23:16];
        2'd1:    data_nxt = head_job.acc[15:8];
        default: data_nxt = head_job.acc[7:0];
      endcase
    end else if (({1'b0, idx_r} + {1'b0, head_job.npad}) >= 3'd4) begin
      data_nxt = PAD_CHAR;
    end else begin
      data_nxt = enc_char(sx);
    end
    last_nxt = head_job.last && end_idx;
  end

  // Hold the output register until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= idx_nxt;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      last_r <= last_nxt;
      err_r  <= head_job.err;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = data_r;
  assign out_last  = last_r;
  assign out_err   = err_r;

endmodule

FILE: rtl/base64_codec.sv
// ----------------------------------------------------------------------------
// base64_codec
// Streaming base64 codec: encode bytes to text or decode text to bytes,
// chosen by the mode register.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid in_stall in_data_in in_last_in | in
//   result  | out_valid out_stall out_data_out        | out
//           | out_last_out out_error_code             |
//   config  | cfg_we cfg_wdata (mode)                 | in
//
// An input item is taken every cycle while the job queue has room; the back
// end emits one result per cycle while not stalled, so encode sustains four
// results per three bytes and the queue stalls the input once it backs up.
// Results pass a queue slot and the output register. Reset is synchronous
// and clears mode, group state, queue, output register; no clearing pass.
// ----------------------------------------------------------------------------
module base64_codec import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_in,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic       out_last_out,
  output logic [1:0] out_error_code
);

  logic q_full, push, pop, head_valid, acc_en;
  job_t push_job, head_job;

  assign in_stall = q_full;
  assign acc_en   = in_valid && !q_full;

  b64c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc_en    (acc_en),
    .data      (in_data_in),
    .last      (in_last_in),
    .push      (push),
    .job       (push_job)
  );

  b64c_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push && acc_en),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data_out),
    .out_last   (out_last_out),
    .out_err    (out_error_code)
  );

endmodule

FILE: bench/tb_base64_codec.sv
// ----------------------------------------------------------------------------
// tb_base64_codec
// Self-checking bench for the streaming base64 codec. A short stimulus table
// covers the alphabet extremes, padding, bad characters and cut-off groups.
// Random buffers follow in both modes under several idle and stall profiles.
// Each result is checked against its typed table row or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_base64_codec;
  import b64c_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 12;
  localparam int unsigned PHASE_ITEMS    = 45;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned MAX_REPORTS    = 40;

  localparam string ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] err;
  } codec_result_t;

  // One row of the directed table; expected values only where typed is set
  typedef struct {
    logic        md;
    logic [7:0]  d;
    logic        l;
    bit          typed;
    int          ecnt;
    logic [31:0] echars;
    logic [1:0]  eerr;
  } stim_row_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       cfg_we         = 1'b0;
  logic       cfg_wdata      = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_data_in     = 8'd0;
  logic       in_last_in     = 1'b0;
  logic       out_stall      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_data_out;
  logic       out_last_out;
  logic [1:0] out_error_code;

  // Model state
  logic        cur_mode;
  logic [23:0] grp_acc;
  logic [1:0]  grp_pos;
  logic        grp_bad;
  logic [1:0]  grp_pads;

  codec_result_t pending_results[$];
  codec_result_t item_results[$];
  codec_result_t want;
  stim_row_t     dir_rows[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;
  int mismatches     = 0;
  int items_sent     = 0;
  int directed_items = 0;
  int results_seen   = 0;
  int bad_char_seen  = 0;
  int incomplete_seen = 0;
  int mode_writes    = 0;

  base64_codec dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_in     (in_data_in),
    .in_last_in     (in_last_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_last_out   (out_last_out),
    .out_error_code (out_error_code)
  );

  // Generate the clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return ALPHABET[s];
  endfunction

  // Look a character up in the alphabet; top bit flags a miss
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    int i;
    for (i = 0; i < 64; i++) begin
      if (ALPHABET[i] == c) return {1'b0, 6'(i)};
    end
    return {1'b1, 6'd0};
  endfunction

  function automatic void clear_group();
    grp_acc  = 24'd0;
    grp_pos  = 2'd0;
    grp_bad  = 1'b0;
    grp_pads = 2'd0;
  endfunction

  // Work out the results caused by one accepted item
  function automatic void predict_codec_item(input logic [7:0] d, input logic l);
    logic [6:0] lookup;
    logic [5:0] v;
    logic [1:0] drop;
    logic [1:0] code;
    int         cnt;
    int         i;
    item_results.delete();
    if (cur_mode == MODE_ENCODE) begin
      grp_acc = grp_acc | ({16'd0, d} << (16 - 8 * grp_pos));
      if (grp_pos == 2'd2) begin
        item_results.push_back('{sextet_char(grp_acc[23:18]), 1'b0, ERR_NONE});
        item_results.push_back('{sextet_char(grp_acc[17:12]), 1'b0, ERR_NONE});
        item_results.push_back('{sextet_char(grp_acc[11:6]), 1'b0, ERR_NONE});
        item_results.push_back('{sextet_char(grp_acc[5:0]), l, ERR_NONE});
        clear_group();
      end else if (!l) begin
        grp_pos++;
      end else begin
        // Pad the short final group
        item_results.push_back('{sextet_char(grp_acc[23:18]), 1'b0, ERR_NONE});
        item_results.push_back('{sextet_char(grp_acc[17:12]), 1'b0, ERR_NONE});
        item_results.push_back('{(grp_pos == 2'd1) ? sextet_char(grp_acc[11:6]) : PAD_CHAR,
                                 1'b0, ERR_NONE});
        item_results.push_back('{PAD_CHAR, 1'b1, ERR_NONE});
        clear_group();
      end
    end else begin
      lookup = char_sextet(d);
      v = lookup[5:0];
      if (d == PAD_CHAR) begin
        v = 6'd0;
        if (grp_pos < 2'd2) grp_bad = 1'b1;
        else grp_pads++;
      end else begin
        if (lookup[6]) begin
          v = 6'd0;
          grp_bad = 1'b1;
        end
        if (grp_pads != 2'd0) grp_bad = 1'b1;
      end
      grp_acc = {grp_acc[17:0], v};
      if (grp_pos < 2'd3) begin
        if (l) begin
          item_results.push_back('{8'd0, 1'b1, ERR_INCOMPLETE});
          clear_group();
        end else begin
          grp_pos++;
        end
      end else begin
        // Drop padded bytes only in a clean final group
        drop = 2'd0;
        if (grp_pads != 2'd0) begin
          if (l && !grp_bad) drop = grp_pads;
          else grp_bad = 1'b1;
        end
        code = grp_bad ? ERR_BAD_CHAR : ERR_NONE;
        cnt = 3 - drop;
        for (i = 0; i < cnt; i++) begin
          item_results.push_back('{grp_acc[23 - 8 * i -: 8], l && (i == cnt - 1), code});
        end
        clear_group();
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, exp_val);
    end
    mismatches++;
  endtask

  // Offer one item, hold it until taken, then log what it should cause
  task automatic send_item(input logic [7:0] d, input logic l, input bit typed = 1'b0,
                           input int ecnt = 0, input logic [31:0] echars = 32'd0,
                           input logic [1:0] eerr = ERR_NONE);
    int k;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data_in <= d;
    in_last_in <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    predict_codec_item(d, l);
    if (typed) begin
      for (k = 0; k < ecnt; k++) begin
        pending_results.push_back('{echars[31 - 8 * k -: 8], l && (k == ecnt - 1), eerr});
      end
    end else begin
      foreach (item_results[k]) pending_results.push_back(item_results[k]);
    end
  endtask

  // Hold the sender until every expected result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
    clear_group();
    mode_writes++;
  endtask

  // Stall the receiver at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_error_code == ERR_BAD_CHAR) bad_char_seen++;
      if (out_error_code == ERR_INCOMPLETE) incomplete_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result data", out_data_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_out !== want.data) report_mismatch("data_out", out_data_out, want.data);
        if (out_last_out !== want.last) report_mismatch("last_out", out_last_out, want.last);
        if (out_error_code !== want.err) begin
          report_mismatch("error_code", out_error_code, want.err);
        end
      end
    end
  end

  // Count cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_base64_codec NOT OK");
    $finish;
  end

  initial begin : stimulus
    int          phase;
    int          sent_in_phase;
    bit          paused;
    int          nbytes;
    int          g;
    int          i;
    int          rem;
    int          kind;
    int          r;
    int          cut;
    bit          close;
    logic [23:0] acc24;
    logic [7:0]  bytes[$];
    logic [7:0]  text[$];
    int          src_prof[4];
    int          sink_prof[4];

    src_prof  = '{0, 49, 0, 10};
    sink_prof = '{0, 0, 49, 10};
    cur_mode = MODE_ENCODE;
    clear_group();

    // Encode: full group, extremes, one and two padding characters
    dir_rows.push_back('{MODE_ENCODE, 8'h4D, 1'b0, 1'b0, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_ENCODE, 8'h61, 1'b0, 1'b0, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_ENCODE, 8'h6E, 1'b1, 1'b0, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 4, "////", ERR_NONE});
    dir_rows.push_back('{MODE_ENCODE, 8'h00, 1'b1, 1'b1, 4, "AA==", ERR_NONE});
    dir_rows.push_back('{MODE_ENCODE, 8'h00, 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_ENCODE, 8'hFF, 1'b1, 1'b1, 4, "AP8=", ERR_NONE});
    // Decode: clean group, padded final groups
    dir_rows.push_back('{MODE_DECODE, "/", 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "/", 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "/", 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "/", 1'b0, 1'b1, 3, 32'hFFFFFF00, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "A", 1'b0, 1'b0, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "P", 1'b0, 1'b0, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "8", 1'b0, 1'b0, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "=", 1'b1, 1'b0, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "A", 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "A", 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "=", 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "=", 1'b1, 1'b1, 1, 32'h0, ERR_NONE});
    // Decode: bad character cut off by last, then misplaced pads
    dir_rows.push_back('{MODE_DECODE, "*", 1'b1, 1'b1, 1, 32'h0, ERR_INCOMPLETE});
    dir_rows.push_back('{MODE_DECODE, "=", 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "A", 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "=", 1'b0, 1'b1, 0, 32'h0, ERR_NONE});
    dir_rows.push_back('{MODE_DECODE, "A", 1'b0, 1'b1, 3, 32'h0, ERR_BAD_CHAR});

    // Reset once
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].md != cur_mode) set_mode(dir_rows[i].md);
      send_item(dir_rows[i].d, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].ecnt,
                dir_rows[i].echars, dir_rows[i].eerr);
    end
    directed_items = items_sent;

    // Random buffers, alternating mode, stepping through idle and stall profiles
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      set_mode((phase % 2) ? MODE_DECODE : MODE_ENCODE);
      src_idle_pct   = src_prof[phase / 2];
      sink_stall_pct = sink_prof[phase / 2];
      sent_in_phase  = 0;
      paused         = 1'b0;
      while (sent_in_phase < PHASE_ITEMS) begin
        if (!paused && sent_in_phase >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        bytes.delete();
        nbytes = $urandom_range(1, 9);
        for (i = 0; i < nbytes; i++) begin
          r = $urandom_range(0, 7);
          bytes.push_back((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
        end
        if (cur_mode == MODE_ENCODE) begin
          close = ($urandom_range(0, 9) != 0);
          for (i = 0; i < nbytes; i++) send_item(bytes[i], close && (i == nbytes - 1));
          sent_in_phase += nbytes;
        end else begin
          // Build well-formed text, then maybe break it
          text.delete();
          for (g = 0; g < nbytes; g += 3) begin
            rem = nbytes - g;
            acc24 = {bytes[g], (rem > 1) ? bytes[g + 1] : 8'h00,
                     (rem > 2) ? bytes[g + 2] : 8'h00};
            text.push_back(sextet_char(acc24[23:18]));
            text.push_back(sextet_char(acc24[17:12]));
            text.push_back((rem > 1) ? sextet_char(acc24[11:6]) : PAD_CHAR);
            text.push_back((rem > 2) ? sextet_char(acc24[5:0]) : PAD_CHAR);
          end
          close = 1'b1;
          kind = $urandom_range(0, 9);
          case (kind)
            0: begin
              text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
            end
            1: begin
              cut = $urandom_range(1, 3);
              repeat (cut) text.delete(text.size() - 1);
            end
            2: begin
              text.insert($urandom_range(0, text.size() - 1), PAD_CHAR);
            end
            3: begin
              text.delete();
              repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
              close = 1'($urandom_range(0, 1));
            end
            4: begin
              close = 1'b0;
            end
            default: begin
            end
          endcase
          for (i = 0; i < text.size(); i++) send_item(text[i], close && (i == text.size() - 1));
          sent_in_phase += text.size();
        end
      end
    end

    // Let the last results out, then idle a little longer
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d items (%0d from the table) in both modes, %0d mode writes.",
             items_sent, directed_items, mode_writes);
    $display("Checked %0d results: %0d with bad characters, %0d cut-off groups.",
             results_seen, bad_char_seen, incomplete_seen);
    if (mismatches == 0) begin
      $display("tb_base64_codec OK");
    end else begin
      $display("tb_base64_codec NOT OK");
    end
    $finish;
  end

endmodule
